// ----- sv/bmhq_pkg.sv -----
// Shared types, constants and helpers for the binary min-heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 16;
    localparam int CNT_W  = 11;
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int REL_W  = POS_W - 1;
    localparam int NLEV   = POS_W;
    localparam int LVL_W  = $clog2(NLEV + 1);
    localparam int LIDX_W = $clog2(NLEV);
    localparam int CAP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t EMPTY_MARK = -16'sd32676;
    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        TK_INS,
        TK_DEL
    } tok_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LAUNCH,
        S_RUN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic             valid;
        tok_kind_t        kind;
        logic [LVL_W-1:0] lvl;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] lim;
        data_t            value;
    } token_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        data_t            data;
    } fill_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } fetch_t;

    typedef struct packed {
        logic             we;
        logic [REL_W-1:0] waddr;
        data_t            wdata;
        logic [REL_W-1:0] ra;
        logic [REL_W-1:0] rb;
    } ram_req_t;

    function automatic logic [LVL_W-1:0] pos_level(input logic [POS_W-1:0] p);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < POS_W; i++)
        begin
            if (p[i])
            begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

    function automatic int level_depth(input int l);
        int full;
        int rest;
        full = 1 << l;
        rest = DEPTH + 1 - full;
        return (full < rest) ? full : rest;
    endfunction

endpackage

// ----- sv/bmhq_req_if.sv -----
// Request channel interface: operation code and value.
`timescale 1ns / 1ps

interface bmhq_req_if import bmhq_pkg::*; ;
    logic  valid;
    logic  ready;
    logic  opcode;
    data_t value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ----- sv/bmhq_rsp_if.sv -----
// Response channel interface: removed minimum, status, count and flags.
`timescale 1ns / 1ps

interface bmhq_rsp_if import bmhq_pkg::*; ;
    logic             valid;
    logic             ready;
    data_t            min_value;
    status_t          status;
    logic [CNT_W-1:0] element_count;
    logic             is_empty;
    logic             is_full;

    modport source (output valid, output min_value, output status, output element_count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input min_value, input status, input element_count,
                    input is_empty, input is_full, output ready);
endinterface

// ----- sv/binary_min_heap_queue.sv -----
// Binary min-heap priority queue built as a chain of per-level cells.
//
// Usage: requests arrive on req (opcode 0 inserts value, opcode 1 removes the
// minimum); each request yields exactly one response on rsp carrying the
// removed minimum, a status code, the element count and the empty/full flags.
// A transaction completes when valid and ready are both high. cfg_we/cfg_wdata
// set the capacity limit; write it only while the queue is idle.
// Each heap level is a cell with its own RAM; an operation walks the chain
// one level at a time, at each level a read, then a compare and pass.
// An insert walks from the root down to the level of the new slot; a
// delete-min first reads the root and the last element, then sinks the last
// element from the root until it stops; the only element, and a full or
// empty request, are answered without a walk. One request is in flight at
// a time.
// The response register decouples the sides: a new request is taken while the
// previous response waits, and the following one completes and then holds
// until rsp.ready frees the register.
// Reset empties the queue and sets the capacity limit to 1024; heap RAM
// contents are not cleared, as only written slots are ever read.
`timescale 1ns / 1ps

module binary_min_heap_queue import bmhq_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    bmhq_req_if.sink         req,
    bmhq_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cap_reg;
    data_t            res_min_reg;
    data_t            res_min_next;
    status_t          res_status_reg;
    status_t          res_status_next;
    token_t           inj_reg;
    token_t           inj_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    data_t            out_min_reg;
    status_t          out_status_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_empty_reg;
    logic             out_full_reg;
    logic             out_load;

    logic [CAP_W-1:0] cap_eff;
    logic             at_cap;
    logic [POS_W-1:0] ins_pos;
    logic [LVL_W-1:0] last_lvl;
    fetch_t           fetch_w;

    token_t   tok_in_w   [NLEV];
    token_t   tok_out_w  [NLEV];
    fill_t    fill_in_w  [NLEV];
    fill_t    fill_out_w [NLEV];
    ram_req_t ram_req_w  [NLEV];
    data_t    qa_w       [NLEV];
    data_t    qb_w       [NLEV];
    logic [NLEV-1:0] cell_done;

    genvar g;
    generate
        for (g = 0; g < NLEV; g++)
        begin : g_lvl
            localparam int LD  = level_depth(g);
            localparam int LAW = (LD > 1) ? $clog2(LD) : 1;

            if (g == 0)
            begin : g_first
                assign tok_in_w[g] = inj_reg;
            end
            else
            begin : g_mid
                assign tok_in_w[g] = tok_out_w[g-1];
            end

            if (g == NLEV - 1)
            begin : g_last
                assign fill_in_w[g] = '0;
            end
            else
            begin : g_inner
                assign fill_in_w[g] = fill_out_w[g+1];
            end

            bmhq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .level    (LVL_W'(g)),
                .tok_in   (tok_in_w[g]),
                .tok_out  (tok_out_w[g]),
                .fill_in  (fill_in_w[g]),
                .fill_out (fill_out_w[g]),
                .fetch    (fetch_w),
                .ram_req  (ram_req_w[g]),
                .ram_qa   (qa_w[g]),
                .ram_qb   (qb_w[g]),
                .done     (cell_done[g])
            );

            bmhq_ram #(
                .WIDTH (DATA_W),
                .DEPTH (LD)
            ) u_ram (
                .clk   (clk),
                .we    (ram_req_w[g].we),
                .waddr (ram_req_w[g].waddr[LAW-1:0]),
                .wdata (ram_req_w[g].wdata),
                .ra    (ram_req_w[g].ra[LAW-1:0]),
                .rb    (ram_req_w[g].rb[LAW-1:0]),
                .qa    (qa_w[g]),
                .qb    (qb_w[g])
            );
        end
    endgenerate

    assign cap_eff  = (CAP_W'(cap_reg) < CAP_W'(DEPTH)) ? CAP_W'(cap_reg) : CAP_W'(DEPTH);
    assign at_cap   = CAP_W'(count_reg) >= cap_eff;
    assign ins_pos  = POS_W'(count_reg) + POS_W'(1);
    assign last_lvl = pos_level(POS_W'(count_reg));
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        res_min_next    = res_min_reg;
        res_status_next = res_status_reg;
        inj_next        = '0;
        fetch_w         = '0;
        req.ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.opcode == OP_INSERT)
                    begin
                        res_min_next = '0;
                        if (at_cap)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            res_status_next = ST_DONE;
                            count_next      = count_reg + CNT_W'(1);
                            inj_next.valid  = 1'b1;
                            inj_next.kind   = TK_INS;
                            inj_next.pos    = ins_pos;
                            inj_next.lvl    = pos_level(ins_pos);
                            inj_next.lim    = ins_pos;
                            inj_next.value  = req.value;
                            state_next      = S_RUN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_min_next    = EMPTY_MARK;
                        res_status_next = ST_EMPTY;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        res_status_next = ST_DONE;
                        state_next      = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                fetch_w.valid = 1'b1;
                fetch_w.pos   = POS_W'(count_reg);
                state_next    = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                res_min_next = qb_w[0];
                count_next   = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    inj_next.valid = 1'b1;
                    inj_next.kind  = TK_DEL;
                    inj_next.pos   = POS_W'(1);
                    inj_next.lvl   = LVL_W'(1);
                    inj_next.lim   = POS_W'(count_reg - CNT_W'(1));
                    inj_next.value = qa_w[last_lvl[LIDX_W-1:0]];
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                if (|cell_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            inj_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_min_reg    <= res_min_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_min_reg    <= res_min_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= count_reg;
            out_empty_reg  <= (count_reg == '0);
            out_full_reg   <= at_cap;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.min_value     = out_min_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.element_count = out_count_reg;
    assign rsp.is_empty      = out_empty_reg;
    assign rsp.is_full       = out_full_reg;

    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_done))
        else $error("more than one level finished in a cycle");

    a_chain_end: assert property (@(posedge clk) disable iff (!rst_n)
        !tok_out_w[NLEV-1].valid && !fill_out_w[0].valid)
        else $error("transaction ran off an end of the level chain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CAP_W'(count_reg) <= CAP_W'(DEPTH))
        else $error("element count beyond heap depth");

    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_EMPTY |-> rsp.element_count == '0 && rsp.is_empty)
        else $error("empty-delete response with non-zero count");

endmodule

// ----- sv/bmhq_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    ra,
    input  logic [AW-1:0]    rb,
    output logic [WIDTH-1:0] qa,
    output logic [WIDTH-1:0] qb
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] qa_reg;
    logic [WIDTH-1:0] qb_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        qa_reg <= mem_reg[ra];
        qb_reg <= mem_reg[rb];
    end

    assign qa = qa_reg;
    assign qb = qb_reg;

endmodule

// ----- sv/bmhq_cell.sv -----
// One heap level: compare-and-pass step for insert and sift-down.
`timescale 1ns / 1ps

module bmhq_cell import bmhq_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LVL_W-1:0] level,
    input  token_t           tok_in,
    output token_t           tok_out,
    input  fill_t            fill_in,
    output fill_t            fill_out,
    input  fetch_t           fetch,
    output ram_req_t         ram_req,
    input  data_t            ram_qa,
    input  data_t            ram_qb,
    output logic             done
);

    token_t tok_out_reg;
    token_t tok_out_next;
    token_t pend_reg;
    token_t pend_next;
    logic   wait_reg;
    logic   wait_next;

    token_t           src;
    logic [POS_W-1:0] mask;
    logic [POS_W-1:0] node;
    logic [REL_W-1:0] node_rel;
    logic [POS_W:0]   c0;
    logic [REL_W-1:0] c0_rel;
    logic             has0;
    logic             has1;
    logic             pick_b;
    data_t            min_val;
    logic [POS_W-1:0] min_pos;

    always_comb
    begin
        src      = wait_reg ? pend_reg : tok_in;
        mask     = (POS_W'(1) << level) - POS_W'(1);
        node     = src.pos >> (src.lvl - level);
        node_rel = REL_W'(node & mask);
        c0       = {src.pos, 1'b0};
        c0_rel   = REL_W'(c0[POS_W-1:0] & mask);
        has0     = c0 <= {1'b0, src.lim};
        has1     = (c0 | (POS_W + 1)'(1)) <= {1'b0, src.lim};
        pick_b   = has1 && ($signed(ram_qb) < $signed(ram_qa));
        min_val  = pick_b ? ram_qb : ram_qa;
        min_pos  = pick_b ? (c0[POS_W-1:0] | POS_W'(1)) : c0[POS_W-1:0];

        tok_out_next  = '0;
        pend_next     = pend_reg;
        wait_next     = 1'b0;
        fill_out      = '0;
        done          = 1'b0;
        ram_req       = '0;
        ram_req.ra    = node_rel;
        ram_req.rb    = c0_rel | REL_W'(1);
        ram_req.waddr = node_rel;
        ram_req.wdata = src.value;

        if (fetch.valid)
        begin
            ram_req.ra = REL_W'(fetch.pos & mask);
            ram_req.rb = '0;
        end

        if (wait_reg)
        begin
            case (pend_reg.kind)
                TK_INS:
                begin
                    tok_out_next = pend_reg;
                    if ($signed(ram_qa) > $signed(pend_reg.value))
                    begin
                        ram_req.we         = 1'b1;
                        tok_out_next.value = ram_qa;
                    end
                end
                TK_DEL:
                begin
                    fill_out.valid = 1'b1;
                    fill_out.pos   = pend_reg.pos;
                    if ($signed(pend_reg.value) > $signed(min_val))
                    begin
                        fill_out.data    = min_val;
                        tok_out_next     = pend_reg;
                        tok_out_next.pos = min_pos;
                        tok_out_next.lvl = level + LVL_W'(1);
                    end
                    else
                    begin
                        fill_out.data = pend_reg.value;
                        done          = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b0;
                end
            endcase
        end
        else if (tok_in.valid)
        begin
            case (tok_in.kind)
                TK_INS:
                begin
                    if (tok_in.lvl == level)
                    begin
                        ram_req.we = 1'b1;
                        done       = 1'b1;
                    end
                    else
                    begin
                        wait_next = 1'b1;
                        pend_next = tok_in;
                    end
                end
                TK_DEL:
                begin
                    if (tok_in.lvl != level)
                    begin
                        tok_out_next = tok_in;
                    end
                    else if (!has0)
                    begin
                        fill_out.valid = 1'b1;
                        fill_out.pos   = tok_in.pos;
                        fill_out.data  = tok_in.value;
                        done           = 1'b1;
                    end
                    else
                    begin
                        ram_req.ra = c0_rel;
                        wait_next  = 1'b1;
                        pend_next  = tok_in;
                    end
                end
                default:
                begin
                    done = 1'b0;
                end
            endcase
        end

        if (fill_in.valid)
        begin
            ram_req.we    = 1'b1;
            ram_req.waddr = REL_W'(fill_in.pos & mask);
            ram_req.wdata = fill_in.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out_reg <= '0;
            wait_reg    <= 1'b0;
        end
        else
        begin
            tok_out_reg <= tok_out_next;
            wait_reg    <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign tok_out = tok_out_reg;

endmodule
